// File: sv/hse_pkg.sv
`timescale 1ns / 1ps

package hse_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = ADDR_W + 2;

  typedef logic signed [31:0] word_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CHILD_W-1:0] child_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOADW,
    ST_RDL,
    ST_RDR,
    ST_CMP,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_EMIT
  } state_t;

endpackage

// File: sv/heap_sort_engine.sv
`timescale 1ns / 1ps

// Heapsort engine for signed 32-bit values, holding up to 32 values per set.
// An item is accepted on a clock edge where start is high and busy is low.
// Items without end_of_set are written straight to memory and busy stays low.
// An item with end_of_set closes the set; values past capacity are dropped
// and every result of that run then carries dropped_items.
// After the closing item busy stays high while the heap is built and sorted.
// One comparator and a memory with one read and one write port do the work:
// a sift-down step reads the left child, reads the right child, then compares
// and writes the larger value back; a build sift first loads its node, and
// each root swap reads the root and the last value and writes the root there.
// The run then comes out in ascending order, one result per cycle on
// consecutive cycles, each marked by result_valid for one cycle, the final
// one with run_last. The receiver cannot stall, so results are never held.
// busy drops in the cycle that presents the final result.
// Synchronous reset empties the set and clears the overflow flag.
module heap_sort_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    sample_value,
  input  logic                  end_of_set,
  output logic                  result_valid,
  output logic signed [31:0]    sorted_value,
  output logic                  run_last,
  output logic                  dropped_items
);
  import hse_pkg::*;

  mem_req_t mem_req;
  word_t    rdata;
  word_t    cmp_b;
  logic     cmp_gt;

  hse_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  hse_cmp u_cmp (
    .a  (rdata),
    .b  (cmp_b),
    .gt (cmp_gt)
  );

  hse_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .sample_value  (sample_value),
    .end_of_set    (end_of_set),
    .busy          (busy),
    .mem_req       (mem_req),
    .rdata         (rdata),
    .cmp_b         (cmp_b),
    .cmp_gt        (cmp_gt),
    .result_valid  (result_valid),
    .run_last      (run_last),
    .dropped_items (dropped_items)
  );

  assign sorted_value = rdata;

endmodule

// File: sv/hse_mem.sv
`timescale 1ns / 1ps

module hse_mem (
  input  logic             clk,
  input  hse_pkg::mem_req_t req,
  output hse_pkg::word_t   rdata
);
  import hse_pkg::*;

  word_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: sv/hse_cmp.sv
`timescale 1ns / 1ps

module hse_cmp (
  input  hse_pkg::word_t a,
  input  hse_pkg::word_t b,
  output logic           gt
);
  import hse_pkg::*;

  assign gt = (a > b);

endmodule

// File: sv/hse_seq.sv
`timescale 1ns / 1ps

module hse_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hse_pkg::word_t    sample_value,
  input  logic              end_of_set,
  output logic              busy,
  output hse_pkg::mem_req_t mem_req,
  input  hse_pkg::word_t    rdata,
  output hse_pkg::word_t    cmp_b,
  input  logic              cmp_gt,
  output logic              result_valid,
  output logic              run_last,
  output logic              dropped_items
);
  import hse_pkg::*;

  state_t state, state_next;
  logic   in_build, in_build_next;
  cnt_t   count, count_next;
  logic   ovf, ovf_next;
  cnt_t   n, n_next;
  addr_t  node, node_next;
  addr_t  k, k_next;
  addr_t  pos, pos_next;
  cnt_t   size, size_next;
  word_t  hold, hold_next;
  addr_t  top_idx, top_idx_next;
  word_t  top_val, top_val_next;
  addr_t  out_idx, out_idx_next;
  logic   result_valid_next, run_last_next, dropped_items_next;

  child_t lc, rc, size_ext;
  logic   sift_end;
  logic   sel_r;
  addr_t  new_idx;
  word_t  new_val;
  cnt_t   n_close;

  assign lc       = {1'b0, pos, 1'b1};
  assign rc       = lc + CHILD_W'(1);
  assign size_ext = CHILD_W'(size);
  assign busy     = (state != ST_IDLE);
  assign cmp_b    = (state == ST_CMP) ? top_val : hold;
  assign sel_r    = (rc < size_ext) && cmp_gt;
  assign new_idx  = sel_r ? ADDR_W'(rc) : top_idx;
  assign new_val  = sel_r ? rdata : top_val;
  assign n_close  = (count < cnt_t'(CAPACITY)) ? count + cnt_t'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      ovf          <= ovf_next;
      result_valid <= result_valid_next;
    end
    in_build      <= in_build_next;
    n             <= n_next;
    node          <= node_next;
    k             <= k_next;
    pos           <= pos_next;
    size          <= size_next;
    hold          <= hold_next;
    top_idx       <= top_idx_next;
    top_val       <= top_val_next;
    out_idx       <= out_idx_next;
    run_last      <= run_last_next;
    dropped_items <= dropped_items_next;
  end

  always_comb begin
    state_next         = state;
    in_build_next      = in_build;
    count_next         = count;
    ovf_next           = ovf;
    n_next             = n;
    node_next          = node;
    k_next             = k;
    pos_next           = pos;
    size_next          = size;
    hold_next          = hold;
    top_idx_next       = top_idx;
    top_val_next       = top_val;
    out_idx_next       = out_idx;
    result_valid_next  = 1'b0;
    run_last_next      = run_last;
    dropped_items_next = dropped_items;
    mem_req            = '0;
    sift_end           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (count < cnt_t'(CAPACITY)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ADDR_W'(count);
            mem_req.wdata = sample_value;
            count_next    = count + cnt_t'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (end_of_set) begin
            n_next = n_close;
            if (n_close < cnt_t'(2)) begin
              out_idx_next = '0;
              state_next   = ST_EMIT;
            end else begin
              in_build_next = 1'b1;
              node_next     = ADDR_W'((n_close >> 1) - cnt_t'(1));
              state_next    = ST_LOAD;
            end
          end
        end
      end
      ST_LOAD: begin
        mem_req.raddr = node;
        state_next    = ST_LOADW;
      end
      ST_LOADW: begin
        hold_next  = rdata;
        pos_next   = node;
        size_next  = n;
        state_next = ST_RDL;
      end
      ST_RDL: begin
        if (lc < size_ext) begin
          mem_req.raddr = ADDR_W'(lc);
          state_next    = ST_RDR;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos;
          mem_req.wdata = hold;
          sift_end      = 1'b1;
        end
      end
      ST_RDR: begin
        if (cmp_gt) begin
          top_idx_next = ADDR_W'(lc);
          top_val_next = rdata;
        end else begin
          top_idx_next = pos;
          top_val_next = hold;
        end
        mem_req.raddr = (rc < size_ext) ? ADDR_W'(rc) : '0;
        state_next    = ST_CMP;
      end
      ST_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        if (new_idx == pos) begin
          mem_req.wdata = hold;
          sift_end      = 1'b1;
        end else begin
          mem_req.wdata = new_val;
          pos_next      = new_idx;
          state_next    = ST_RDL;
        end
      end
      ST_SW0: begin
        mem_req.raddr = '0;
        state_next    = ST_SW1;
      end
      ST_SW1: begin
        top_val_next  = rdata;
        mem_req.raddr = k;
        state_next    = ST_SW2;
      end
      ST_SW2: begin
        hold_next     = rdata;
        mem_req.we    = 1'b1;
        mem_req.waddr = k;
        mem_req.wdata = top_val;
        pos_next      = '0;
        size_next     = cnt_t'(k);
        state_next    = ST_RDL;
      end
      ST_EMIT: begin
        mem_req.raddr      = out_idx;
        result_valid_next  = 1'b1;
        dropped_items_next = ovf;
        run_last_next      = (cnt_t'(out_idx) == n - cnt_t'(1));
        out_idx_next       = out_idx + ADDR_W'(1);
        if (cnt_t'(out_idx) == n - cnt_t'(1)) begin
          count_next = '0;
          ovf_next   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (sift_end) begin
      if (in_build) begin
        if (node == '0) begin
          in_build_next = 1'b0;
          k_next        = ADDR_W'(n - cnt_t'(1));
          state_next    = ST_SW0;
        end else begin
          node_next  = node - ADDR_W'(1);
          state_next = ST_LOAD;
        end
      end else if (k == ADDR_W'(1)) begin
        out_idx_next = '0;
        state_next   = ST_EMIT;
      end else begin
        k_next     = k - ADDR_W'(1);
        state_next = ST_SW0;
      end
    end
  end

endmodule
